FILE: sv/bsa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator package
// Request and result types, operation codes, controller states and the
// lowest-set-bit search used on one word of the occupancy bitmap.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int WORD_W = 16;
  localparam int BIT_W  = 4;
  localparam int SLOT_W = 7;
  localparam int FREE_W = 7;

  typedef enum logic [1:0] {
    FN_ALLOC   = 2'd0,
    FN_RELEASE = 2'd1,
    FN_FIND    = 2'd2
  } bsa_func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_RESP
  } bsa_state_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [SLOT_W-1:0] slot;
  } bsa_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic              ok;
    logic [FREE_W-1:0] free_count;
  } bsa_out_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } bsa_hit_t;

  function automatic bsa_hit_t bsa_lowest(input logic [WORD_W-1:0] v);
    bsa_hit_t h;
    h.found = 1'b0;
    h.idx   = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (v[j]) begin
        h.found = 1'b1;
        h.idx   = BIT_W'(j);
      end
    end
    return h;
  endfunction

endpackage

FILE: sv/bsa_mem.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator occupancy memory
// One occupancy word per entry, registered read data, one write port. A
// per-word valid bit cleared at reset makes unwritten words read as all free.
// ----------------------------------------------------------------------------
module bsa_mem #(
  parameter int WORDS = 4,
  parameter int AW    = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [bsa_pkg::WORD_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [bsa_pkg::WORD_W-1:0] wr_data
);
  import bsa_pkg::*;

  logic [WORD_W-1:0] mem_r [WORDS];
  logic [WORDS-1:0]  valid_r;
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem_r[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/bsa_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator controller
// Takes one request at a time, scans or updates the occupancy memory one word
// per read, keeps the free-slot count and holds the result register.
// ----------------------------------------------------------------------------
module bsa_ctrl #(
  parameter int SLOTS = 64,
  parameter int WORDS = 4,
  parameter int AW    = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bsa_pkg::bsa_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bsa_pkg::bsa_out_t         out_data,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  input  logic [bsa_pkg::WORD_W-1:0] rd_data,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic [bsa_pkg::WORD_W-1:0] wr_data
);
  import bsa_pkg::*;

  localparam int IW  = $clog2(SLOTS + 1);
  localparam int CW0 = (IW > SLOT_W) ? IW : SLOT_W;
  localparam int CW  = (CW0 > AW + BIT_W) ? CW0 : AW + BIT_W;

  bsa_state_t        state_r, state_nxt;
  logic [1:0]        func_r, func_nxt;
  logic [AW-1:0]     word_r, word_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic              first_r, first_nxt;
  logic [IW-1:0]     free_r, free_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic              out_valid_r, out_valid_nxt;
  bsa_out_t          out_data_r, out_data_nxt;

  logic [CW-1:0]     s_c;
  logic [CW-1:0]     start_c;
  logic [CW-1:0]     idx_c;
  logic [WORD_W-1:0] wmask;
  logic [WORD_W-1:0] cand;
  bsa_hit_t          hit;
  logic [CW-1:0]     hit_num;
  logic              last_word;

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      wmask[j] = (CW'({word_r, BIT_W'(j)}) < CW'(SLOTS));
    end
  end

  always_comb begin
    case (func_r)
      FN_ALLOC: cand = ~rd_data & wmask;
      FN_FIND:  cand = rd_data & wmask &
                       (first_r ? ~((WORD_W'(1) << bit_r) - WORD_W'(1)) : {WORD_W{1'b1}});
      default:  cand = '0;
    endcase
  end

  assign hit       = bsa_lowest(cand);
  assign hit_num   = CW'({word_r, hit.idx}) + CW'(1);
  assign last_word = (word_r == AW'(WORDS - 1));
  assign s_c       = CW'(in_data.slot);
  assign start_c   = (s_c == '0) ? CW'(1) : s_c;
  assign idx_c     = start_c - CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      free_r      <= IW'(SLOTS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    word_r     <= word_nxt;
    bit_r      <= bit_nxt;
    first_r    <= first_nxt;
    res_slot_r <= res_slot_nxt;
    res_ok_r   <= res_ok_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    word_nxt      = word_r;
    bit_nxt       = bit_r;
    first_nxt     = first_r;
    free_nxt      = free_r;
    res_slot_nxt  = res_slot_r;
    res_ok_nxt    = res_ok_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = word_r;
    wr_en         = 1'b0;
    wr_addr       = word_r;
    wr_data       = rd_data;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          func_nxt     = in_data.func;
          res_slot_nxt = '0;
          res_ok_nxt   = 1'b0;
          first_nxt    = 1'b0;
          word_nxt     = AW'(idx_c >> BIT_W);
          bit_nxt      = idx_c[BIT_W-1:0];
          state_nxt    = ST_RESP;
          case (in_data.func)
            FN_ALLOC: begin
              word_nxt = '0;
              if (free_r != '0) begin
                state_nxt = ST_READ;
              end
            end
            FN_RELEASE: begin
              if (s_c != '0 && s_c <= CW'(SLOTS)) begin
                state_nxt = ST_READ;
              end
            end
            FN_FIND: begin
              first_nxt = 1'b1;
              if (start_c <= CW'(SLOTS)) begin
                state_nxt = ST_READ;
              end
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = ST_RESP;
        case (func_r)
          FN_ALLOC: begin
            if (hit.found) begin
              wr_en        = 1'b1;
              wr_data      = rd_data | (WORD_W'(1) << hit.idx);
              free_nxt     = free_r - IW'(1);
              res_slot_nxt = SLOT_W'(hit_num);
              res_ok_nxt   = 1'b1;
            end else if (!last_word) begin
              word_nxt  = word_r + AW'(1);
              state_nxt = ST_READ;
            end
          end
          FN_RELEASE: begin
            wr_en      = 1'b1;
            wr_data    = rd_data & ~(WORD_W'(1) << bit_r);
            res_ok_nxt = 1'b1;
            if (rd_data[bit_r]) begin
              free_nxt = free_r + IW'(1);
            end
          end
          FN_FIND: begin
            if (hit.found) begin
              res_slot_nxt = SLOT_W'(hit_num);
              res_ok_nxt   = 1'b1;
            end else if (!last_word) begin
              word_nxt  = word_r + AW'(1);
              first_nxt = 1'b0;
              state_nxt = ST_READ;
            end
          end
          default: begin
            state_nxt = ST_RESP;
          end
        endcase
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.slot_out   = res_slot_r;
          out_data_nxt.ok         = res_ok_r;
          out_data_nxt.free_count = FREE_W'(free_r);
          out_valid_nxt           = 1'b1;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(free_r) <= CW'(SLOTS))
    else $error("free count above slot total");

  a_write_in_check: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> state_r == ST_CHECK)
    else $error("memory write outside check state");

  a_read_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> state_r == ST_READ)
    else $error("memory read outside read state");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r != ST_IDLE)
    else $error("request accepted but controller stayed idle");

  a_alloc_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK && func_r == FN_ALLOC && hit.found) |=> free_r == $past(free_r) - IW'(1))
    else $error("allocation did not lower the free count");
`endif

endmodule

FILE: sv/bitmap_slot_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator
// First-fit allocator over an occupancy bitmap of SLOTS slots numbered from 1,
// with allocate, release and find-next-occupied requests.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on in_valid/in_ready with in_data (func, slot); each request
// gives exactly one result on out_valid/out_ready with out_data (slot_out, ok,
// free_count). One request is in work at a time; in_ready is high while idle.
// The bitmap lives in a memory of 16-bit words with a registered read. Each
// word examined passes through a read state and then a check state, which
// writes it back on an allocation hit or a release; a request rejected at
// once goes straight to the response state, which loads the result. A
// release examines one word; a search examines the words from its start word
// onward. The controller returns to idle as the result is loaded and can
// then accept the next request. Reset clears every slot to free through
// per-word valid bits and sets the free count to SLOTS. While the receiver
// stalls, the result waits in the output register; a following request can
// still be taken and processed, and it then waits to load the output until
// the previous result is taken.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator #(
  parameter int SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bsa_pkg::bsa_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bsa_pkg::bsa_out_t out_data
);
  import bsa_pkg::*;

  localparam int WORDS = (SLOTS + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  bsa_mem #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bsa_ctrl #(
    .SLOTS (SLOTS),
    .WORDS (WORDS),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

endmodule
